// ----- hw/rtl/efd_pkg.sv -----
// ---------------------------------------------------------------------------
// efd_pkg: shared types and constants
// Framing bytes, op codes between front and back, and the result item type.
// ---------------------------------------------------------------------------
package efd_pkg;

	localparam int BODY_CAPACITY_DEF = 256;
	localparam int MIN_BODY          = 10;
	localparam int FIXED_SPAN        = 8;
	localparam int CSUM_SPAN         = 2;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam logic [7:0] TAIL_MARK  = 8'h7E;
	localparam logic [7:0] ESC_MARK   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_TAIL  = 2'd1,
		OP_ABORT = 2'd2
	} op_kind_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_LEN_SHORT = 3'd2;
	localparam logic [2:0] ST_CSUM_BAD  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] body_value;
		logic [7:0] body_index;
		logic [2:0] frame_status;
		logic [7:0] frame_command;
		logic [7:0] frame_subcommand;
		logic [7:0] frame_data_length;
		logic [8:0] frame_body_length;
	} res_t;

endpackage

// ----- hw/rtl/efd_fifo.sv -----
// ---------------------------------------------------------------------------
// efd_fifo: small register queue
// Generic first-in first-out queue with combinational head and count status.
// ---------------------------------------------------------------------------
module efd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fifo count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full fifo");
	a_not_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("fifo full and empty at once");

endmodule

// ----- hw/rtl/efd_front.sv -----
// ---------------------------------------------------------------------------
// efd_front: header hunt, unescaping and body counting
// Turns raw bytes into store, tail and abort ops for the checker.
// ---------------------------------------------------------------------------
module efd_front #(
	parameter int BODY_CAPACITY = efd_pkg::BODY_CAPACITY_DEF,
	parameter int CW            = $clog2(BODY_CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	output logic                op_valid,
	output efd_pkg::op_kind_t   op_kind,
	output logic [7:0]          op_value,
	output logic [CW-1:0]       op_count
);

	typedef enum logic [1:0] {
		HUNT,
		HDR2,
		BODY,
		ESCP
	} phase_t;

	phase_t        phase_q;
	logic [CW-1:0] cnt_q;
	logic          has_room;

	assign has_room = (cnt_q < CW'(BODY_CAPACITY));
	assign op_count = cnt_q;

	always_comb begin
		op_valid = 1'b0;
		op_kind  = efd_pkg::OP_STORE;
		op_value = rx_byte;
		unique case (phase_q)
			HUNT, HDR2: begin
				op_valid = 1'b0;
			end
			BODY: begin
				if (rx_byte == efd_pkg::TAIL_MARK) begin
					op_valid = accept;
					op_kind  = efd_pkg::OP_TAIL;
				end else if (rx_byte != efd_pkg::ESC_MARK) begin
					op_valid = accept;
					op_kind  = has_room ? efd_pkg::OP_STORE : efd_pkg::OP_ABORT;
				end
			end
			ESCP: begin
				op_valid = accept && has_room;
				op_value = rx_byte ^ efd_pkg::ESC_XOR;
			end
			default: begin
				op_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT;
			cnt_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				HUNT: begin
					if (rx_byte == efd_pkg::HDR_FIRST) phase_q <= HDR2;
				end
				HDR2: begin
					if (rx_byte == efd_pkg::HDR_SECOND) begin
						phase_q <= BODY;
						cnt_q   <= '0;
					end else if (rx_byte != efd_pkg::HDR_FIRST) begin
						phase_q <= HUNT;
					end
				end
				BODY: begin
					if (rx_byte == efd_pkg::ESC_MARK) begin
						phase_q <= ESCP;
					end else if (rx_byte == efd_pkg::TAIL_MARK) begin
						phase_q <= HUNT;
					end else if (has_room) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						phase_q <= HUNT;
					end
				end
				ESCP: begin
					phase_q <= BODY;
					if (has_room) cnt_q <= cnt_q + CW'(1);
				end
				default: begin
					phase_q <= HUNT;
				end
			endcase
		end
	end

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(BODY_CAPACITY))
		else $error("body count beyond capacity");
	a_no_op_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == HUNT || phase_q == HDR2) |-> !op_valid)
		else $error("op issued while hunting header");
	a_abort_full: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && op_kind == efd_pkg::OP_ABORT) |-> !has_room)
		else $error("abort with room left");

endmodule

// ----- hw/rtl/efd_back.sv -----
// ---------------------------------------------------------------------------
// efd_back: frame field capture, running checksum and verdict
// Executes one op per cycle while op_take is high and forms one result item per op.
// ---------------------------------------------------------------------------
module efd_back #(
	parameter int CW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_take,
	input  efd_pkg::op_kind_t op_kind,
	input  logic [7:0]        op_value,
	input  logic [CW-1:0]     op_count,
	output efd_pkg::res_t     res
);

	logic [15:0] pl_q, sum_q, rc_q;
	logic [7:0]  cmd_q, sub_q;

	logic        first;
	logic [15:0] pl_b, sum_b, rc_b, pl_n, sum_n, rc_n;
	logic [7:0]  cmd_b, sub_b, cmd_n, sub_n;
	logic [16:0] idx;
	logic [16:0] sum_end;
	logic [17:0] need_len;
	logic        is_store;

	assign is_store = (op_kind == efd_pkg::OP_STORE);
	assign idx      = 17'(op_count);
	assign first    = (idx == '0);
	assign pl_b     = first ? '0 : pl_q;
	assign sum_b    = first ? '0 : sum_q;
	assign rc_b     = first ? '0 : rc_q;
	assign cmd_b    = first ? '0 : cmd_q;
	assign sub_b    = first ? '0 : sub_q;

	always_comb begin
		pl_n = pl_b;
		if (idx == 17'd2) pl_n = {pl_b[15:8], op_value};
		if (idx == 17'd3) pl_n = {op_value, pl_b[7:0]};
		sum_end = 17'(efd_pkg::FIXED_SPAN) + {1'b0, pl_n};
		cmd_n = (idx == 17'd1) ? op_value : cmd_b;
		sum_n = (idx < sum_end) ? sum_b + {8'd0, op_value} : sum_b;
		sub_n = (idx == 17'(efd_pkg::FIXED_SPAN) && pl_n != '0) ? op_value : sub_b;
		rc_n  = rc_b;
		if (idx == sum_end) rc_n = {rc_b[15:8], op_value};
		if (idx == sum_end + 17'd1) rc_n = {op_value, rc_b[7:0]};
	end

	assign need_len = 18'(efd_pkg::FIXED_SPAN + efd_pkg::CSUM_SPAN) + {2'b0, pl_q};

	always_comb begin
		res = '0;
		unique case (op_kind)
			efd_pkg::OP_STORE: begin
				res.body_value = op_value;
				res.body_index = 8'(op_count);
			end
			efd_pkg::OP_TAIL: begin
				res.result_kind       = 1'b1;
				res.frame_body_length = 9'(op_count);
				if (17'(op_count) < 17'(efd_pkg::MIN_BODY)) begin
					res.frame_status = efd_pkg::ST_TOO_SHORT;
				end else if (18'(op_count) < need_len) begin
					res.frame_status = efd_pkg::ST_LEN_SHORT;
				end else if (sum_q != rc_q) begin
					res.frame_status = efd_pkg::ST_CSUM_BAD;
				end else begin
					res.frame_status  = efd_pkg::ST_OK;
					res.frame_command = cmd_q;
					if (pl_q != '0) begin
						res.frame_subcommand  = sub_q;
						res.frame_data_length = 8'(pl_q - 16'd1);
					end
				end
			end
			efd_pkg::OP_ABORT: begin
				res.result_kind       = 1'b1;
				res.frame_status      = efd_pkg::ST_OVERFLOW;
				res.frame_body_length = 9'(op_count);
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q  <= '0;
			sum_q <= '0;
			rc_q  <= '0;
			cmd_q <= '0;
			sub_q <= '0;
		end else if (op_take && is_store) begin
			pl_q  <= pl_n;
			sum_q <= sum_n;
			rc_q  <= rc_n;
			cmd_q <= cmd_n;
			sub_q <= sub_n;
		end
	end

	a_store_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && is_store) |-> !res.result_kind)
		else $error("store op gave a verdict");
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && op_kind == efd_pkg::OP_TAIL && res.frame_status == efd_pkg::ST_OK)
		|-> (18'(op_count) >= need_len))
		else $error("ok verdict on short body");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(op_take && is_store) |-> $stable(sum_q))
		else $error("checksum moved without a store");

endmodule

// ----- hw/rtl/escaped_frame_deframer_checker.sv -----
// ---------------------------------------------------------------------------
// escaped_frame_deframer_checker: byte-stuffed frame parser with sum16 check
// Front unescapes and counts, back checks fields; queues decouple the two.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while the op queue is not full; the front stalls on full.
// Path: a byte's op is written to the op queue when the byte is taken; the back then
//   executes it from the queue head and writes its result item into the result queue.
// Reset: arst_n clears parse phase, body count, checksum state and both
//   queues at once; no clearing pass.
module escaped_frame_deframer_checker #(
	parameter int BODY_CAPACITY = efd_pkg::BODY_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic       pop,
	output logic       empty,
	output logic       result_kind,
	output logic [7:0] body_value,
	output logic [7:0] body_index,
	output logic [2:0] frame_status,
	output logic [7:0] frame_command,
	output logic [7:0] frame_subcommand,
	output logic [7:0] frame_data_length,
	output logic [8:0] frame_body_length
);

	localparam int CW   = $clog2(BODY_CAPACITY + 1);
	localparam int OP_W = 2 + 8 + CW;
	localparam int RW   = $bits(efd_pkg::res_t);

	logic              accept;
	logic              op_valid;
	efd_pkg::op_kind_t op_kind;
	logic [7:0]        op_value;
	logic [CW-1:0]     op_count;
	logic [OP_W-1:0]   op_wdata, op_rdata;
	logic              opq_empty;
	logic              op_take;
	efd_pkg::res_t     res, res_head;
	logic              resq_full;
	logic [RW-1:0]     res_rdata;

	assign accept   = push && !full;
	assign op_wdata = {op_kind, op_value, op_count};

	efd_front #(
		.BODY_CAPACITY(BODY_CAPACITY),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx_byte),
		.op_valid(op_valid),
		.op_kind(op_kind),
		.op_value(op_value),
		.op_count(op_count)
	);

	efd_fifo #(
		.WIDTH(OP_W),
		.DEPTH(efd_pkg::QUEUE_DEPTH)
	) u_opq (
		.clk(clk),
		.arst_n(arst_n),
		.push(op_valid),
		.wdata(op_wdata),
		.full(full),
		.pop(op_take),
		.rdata(op_rdata),
		.empty(opq_empty)
	);

	assign op_take = !opq_empty && !resq_full;

	efd_back #(
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_take(op_take),
		.op_kind(efd_pkg::op_kind_t'(op_rdata[OP_W-1 -: 2])),
		.op_value(op_rdata[CW+7 -: 8]),
		.op_count(op_rdata[CW-1:0]),
		.res(res)
	);

	efd_fifo #(
		.WIDTH(RW),
		.DEPTH(efd_pkg::QUEUE_DEPTH)
	) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(op_take),
		.wdata(res),
		.full(resq_full),
		.pop(pop),
		.rdata(res_rdata),
		.empty(empty)
	);

	assign res_head          = efd_pkg::res_t'(res_rdata);
	assign result_kind       = res_head.result_kind;
	assign body_value        = res_head.body_value;
	assign body_index        = res_head.body_index;
	assign frame_status      = res_head.frame_status;
	assign frame_command     = res_head.frame_command;
	assign frame_subcommand  = res_head.frame_subcommand;
	assign frame_data_length = res_head.frame_data_length;
	assign frame_body_length = res_head.frame_body_length;

	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> !resq_full)
		else $error("op taken with result queue full");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid |-> !full)
		else $error("op issued into full queue");
	a_head_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown(res_rdata))
		else $error("unknown result item at head");

endmodule

// ----- bench/escaped_frame_deframer_checker_tb.sv -----
// ---------------------------------------------------------------------------
// escaped_frame_deframer_checker_tb: self-checking bench for the deframer
// Feeds raw link bytes (noise, broken headers, good, bad and cut frames,
// frames at and past body capacity) and checks every body byte and every
// frame verdict against a byte-level parser model kept in the bench.
// ---------------------------------------------------------------------------
module escaped_frame_deframer_checker_tb;

	localparam int BODY_CAP = efd_pkg::BODY_CAPACITY_DEF;

	typedef enum logic [1:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		IN_BODY,
		AFTER_ESC
	} parse_phase_t;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_SUM,
		FRAME_CUT,
		FRAME_EXTRA,
		FRAME_OVERFLOW,
		FRAME_ESC_FULL
	} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] rx_byte = 8'h00;
	logic       pop = 1'b0;
	logic       empty;
	logic       result_kind;
	logic [7:0] body_value;
	logic [7:0] body_index;
	logic [2:0] frame_status;
	logic [7:0] frame_command;
	logic [7:0] frame_subcommand;
	logic [7:0] frame_data_length;
	logic [8:0] frame_body_length;

	escaped_frame_deframer_checker #(
		.BODY_CAPACITY(BODY_CAP)
	) uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.rx_byte          (rx_byte),
		.pop              (pop),
		.empty            (empty),
		.result_kind      (result_kind),
		.body_value       (body_value),
		.body_index       (body_index),
		.frame_status     (frame_status),
		.frame_command    (frame_command),
		.frame_subcommand (frame_subcommand),
		.frame_data_length(frame_data_length),
		.frame_body_length(frame_body_length)
	);

	always #5 clk = ~clk;

	logic [7:0]    link_bytes[$];
	efd_pkg::res_t frame_results_due[$];
	int            bytes_taken = 0;
	int            mismatch_count = 0;
	logic          gaps_on;

	// parser state
	parse_phase_t pr_phase = HUNT_FIRST;
	logic [8:0]   pr_count = '0;
	logic [15:0]  pr_sum = '0;
	logic [15:0]  pr_len = '0;
	logic [7:0]   pr_cmd = '0;
	logic [7:0]   pr_sub = '0;
	logic [15:0]  pr_csum = '0;

	assign gaps_on = !(bytes_taken >= 120 && bytes_taken < 300);

	function automatic void store_body(logic [7:0] v);
		efd_pkg::res_t r;
		int            sum_end;
		r = '0;
		if (pr_count == 1) pr_cmd = v;
		if (pr_count == 2) pr_len[7:0] = v;
		if (pr_count == 3) pr_len[15:8] = v;
		sum_end = efd_pkg::FIXED_SPAN + int'(pr_len);
		if (int'(pr_count) < sum_end) pr_sum = pr_sum + v;
		if (pr_count == efd_pkg::FIXED_SPAN && pr_len != 0) pr_sub = v;
		if (int'(pr_count) == sum_end) pr_csum[7:0] = v;
		if (int'(pr_count) == sum_end + 1) pr_csum[15:8] = v;
		r.body_value = v;
		r.body_index = pr_count[7:0];
		pr_count = pr_count + 1'b1;
		frame_results_due.push_back(r);
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		efd_pkg::res_t r;
		r = '0;
		r.result_kind = 1'b1;
		r.frame_body_length = pr_count;
		case (pr_phase)
			HUNT_FIRST: begin
				if (b == efd_pkg::HDR_FIRST) pr_phase = HUNT_SECOND;
			end
			HUNT_SECOND: begin
				if (b == efd_pkg::HDR_SECOND) begin
					pr_phase = IN_BODY;
					pr_count = '0;
					pr_sum = '0;
					pr_len = '0;
					pr_cmd = '0;
					pr_sub = '0;
					pr_csum = '0;
				end else if (b != efd_pkg::HDR_FIRST) begin
					pr_phase = HUNT_FIRST;
				end
			end
			IN_BODY: begin
				if (b == efd_pkg::ESC_MARK) begin
					pr_phase = AFTER_ESC;
				end else if (b == efd_pkg::TAIL_MARK) begin
					pr_phase = HUNT_FIRST;
					if (pr_count < efd_pkg::MIN_BODY) begin
						r.frame_status = efd_pkg::ST_TOO_SHORT;
					end else if (int'(pr_count) < efd_pkg::FIXED_SPAN + int'(pr_len)
						+ efd_pkg::CSUM_SPAN) begin
						r.frame_status = efd_pkg::ST_LEN_SHORT;
					end else if (pr_sum != pr_csum) begin
						r.frame_status = efd_pkg::ST_CSUM_BAD;
					end else begin
						r.frame_status = efd_pkg::ST_OK;
						r.frame_command = pr_cmd;
						if (pr_len != 0) begin
							r.frame_subcommand = pr_sub;
							r.frame_data_length = 8'(pr_len - 16'd1);
						end
					end
					frame_results_due.push_back(r);
				end else if (pr_count < BODY_CAP) begin
					store_body(b);
				end else begin
					pr_phase = HUNT_FIRST;
					r.frame_status = efd_pkg::ST_OVERFLOW;
					frame_results_due.push_back(r);
				end
			end
			AFTER_ESC: begin
				// escaped byte at capacity is dropped silently
				pr_phase = IN_BODY;
				if (pr_count < BODY_CAP) store_body(b ^ efd_pkg::ESC_XOR);
			end
		endcase
	endfunction

	function automatic string fmt_result(efd_pkg::res_t r);
		return $sformatf("kind=%0d val=%02h idx=%0d st=%0d cmd=%02h sub=%02h dlen=%0d blen=%0d",
			r.result_kind, r.body_value, r.body_index, r.frame_status,
			r.frame_command, r.frame_subcommand, r.frame_data_length, r.frame_body_length);
	endfunction

	function automatic void note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, what);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (push && !full) begin
				deframe_byte(rx_byte);
				bytes_taken++;
			end
			if (!push || !full) begin
				if (link_bytes.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 8)) begin
					push <= 1'b1;
					rx_byte <= link_bytes.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		efd_pkg::res_t got;
		efd_pkg::res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got = {result_kind, body_value, body_index, frame_status, frame_command,
					frame_subcommand, frame_data_length, frame_body_length};
				if (frame_results_due.size() == 0) begin
					note_mismatch({"unexpected item: ", fmt_result(got)});
				end else begin
					want = frame_results_due.pop_front();
					if (got.result_kind !== want.result_kind
						|| got.body_value !== want.body_value
						|| got.body_index !== want.body_index
						|| got.frame_status !== want.frame_status
						|| got.frame_command !== want.frame_command
						|| got.frame_subcommand !== want.frame_subcommand
						|| got.frame_data_length !== want.frame_data_length
						|| got.frame_body_length !== want.frame_body_length)
						note_mismatch({"expected ", fmt_result(want), " got ", fmt_result(got)});
				end
			end
			pop <= !(gaps_on && $urandom_range(0, 99) < 8);
		end
	end

	function automatic void add_body(logic [7:0] v);
		if (v == efd_pkg::ESC_MARK || v == efd_pkg::TAIL_MARK || $urandom_range(0, 99) < 5) begin
			link_bytes.push_back(efd_pkg::ESC_MARK);
			link_bytes.push_back(v ^ efd_pkg::ESC_XOR);
		end else begin
			link_bytes.push_back(v);
		end
	endfunction

	function automatic void add_header();
		link_bytes.push_back(efd_pkg::HDR_FIRST);
		repeat ($urandom_range(0, 2)) link_bytes.push_back(efd_pkg::HDR_FIRST);
		link_bytes.push_back(efd_pkg::HDR_SECOND);
	endfunction

	function automatic void add_frame(int plen, frame_kind_t kind);
		logic [7:0]  body[$];
		logic [15:0] csum;
		int          keep;
		body.push_back(8'($urandom));
		body.push_back(8'($urandom));
		body.push_back(plen[7:0]);
		body.push_back(plen[15:8]);
		repeat (4 + plen) body.push_back(8'($urandom));
		csum = '0;
		foreach (body[i]) csum = csum + body[i];
		body.push_back(csum[7:0]);
		body.push_back(csum[15:8]);
		case (kind)
			FRAME_BAD_SUM: begin
				body[body.size() - 2 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
			end
			FRAME_CUT: begin
				if ($urandom_range(0, 1)) begin
					body[2] = 8'($urandom);
					body[3] = 8'($urandom);
				end
				keep = $urandom_range(0, body.size() - 1);
				while (body.size() > keep) body.delete(body.size() - 1);
			end
			FRAME_EXTRA: begin
				if (body.size() < BODY_CAP - 4)
					repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
			end
			FRAME_OVERFLOW, FRAME_ESC_FULL: begin
				while (body.size() < BODY_CAP) body.push_back(8'($urandom));
			end
			default: ;
		endcase
		add_header();
		foreach (body[i]) add_body(body[i]);
		if (kind == FRAME_ESC_FULL) begin
			link_bytes.push_back(efd_pkg::ESC_MARK);
			link_bytes.push_back(8'($urandom));
		end
		if (kind == FRAME_OVERFLOW || kind == FRAME_ESC_FULL)
			link_bytes.push_back(8'($urandom_range(0, 8'h7C)));
		link_bytes.push_back(efd_pkg::TAIL_MARK);
	endfunction

	initial begin
		int          frame_no;
		int          plen;
		int          pick;
		frame_kind_t kind;

		// lone second header byte, broken header, repeated first header byte
		link_bytes = '{efd_pkg::HDR_SECOND, efd_pkg::HDR_FIRST, 8'h00, efd_pkg::HDR_FIRST,
			efd_pkg::HDR_FIRST, efd_pkg::HDR_FIRST, efd_pkg::HDR_SECOND};
		// escaped escape, escaped tail, header bytes as data, byte extremes, short tail
		link_bytes = {link_bytes, efd_pkg::ESC_MARK, efd_pkg::ESC_MARK, efd_pkg::ESC_MARK,
			efd_pkg::TAIL_MARK, efd_pkg::HDR_FIRST, efd_pkg::HDR_SECOND, 8'h00, 8'hFF,
			efd_pkg::TAIL_MARK};
		// empty body
		link_bytes = {link_bytes, efd_pkg::HDR_FIRST, efd_pkg::HDR_SECOND, efd_pkg::TAIL_MARK};

		frame_no = 0;
		while (link_bytes.size() < 450) begin
			if ($urandom_range(0, 99) < 15)
				repeat ($urandom_range(1, 3)) link_bytes.push_back(8'($urandom_range(0, 8'hA9)));
			if ($urandom_range(0, 99) < 7) begin
				link_bytes.push_back(efd_pkg::HDR_FIRST);
				link_bytes.push_back(8'($urandom_range(0, 8'h54)));
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) plen = $urandom_range(0, 6);
			else if (pick < 95) plen = $urandom_range(7, 40);
			else plen = $urandom_range(41, 64);
			pick = $urandom_range(0, 99);
			if (pick < 60) kind = FRAME_GOOD;
			else if (pick < 72) kind = FRAME_BAD_SUM;
			else if (pick < 88) kind = FRAME_CUT;
			else kind = FRAME_EXTRA;
			case (frame_no)
				1: add_frame(0, FRAME_GOOD);
				2: add_frame(1, FRAME_GOOD);
				3: add_frame($urandom_range(0, 6), FRAME_ESC_FULL);
				default: add_frame(plen, kind);
			endcase
			frame_no++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (link_bytes.size() != 0 || push || frame_results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && frame_results_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
